// File: rtl/kce_pkg.sv
// Package for the keyframe curve evaluator: widths, codes, state enum.
// No dependencies.
package kce_pkg;
  localparam int unsigned MaxPointsDef = 16;
  localparam int unsigned XW = 17;
  localparam int unsigned AW = 16;
  localparam int unsigned OW = 15;
  localparam int unsigned SW = 3;
  localparam logic [XW-1:0] OneX = 17'h10000;
  localparam logic [OW-1:0] OneAlpha = 15'd16384;

  localparam logic [SW-1:0] StEval = 3'd0;
  localparam logic [SW-1:0] StIns = 3'd1;
  localparam logic [SW-1:0] StRepl = 3'd2;
  localparam logic [SW-1:0] StFull = 3'd3;
  localparam logic [SW-1:0] StEndp = 3'd4;

  localparam logic [1:0] ModeLin = 2'd0;
  localparam logic [1:0] ModeCr = 2'd1;

  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegStart = 2'd1;
  localparam logic [1:0] RegEnd = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_SHIFT, S_WRITE, S_FETCH, S_DIV, S_POLY, S_DONE
  } state_e;

  function automatic logic [OW-1:0] clamp_alpha(input logic signed [47:0] v);
    if (v < 0) return '0;
    if (v > 48'sd16384) return OneAlpha;
    return v[OW-1:0];
  endfunction
endpackage

// File: rtl/kce_if.sv
// Valid/ready channel interfaces for the keyframe curve evaluator.
// Depends on nothing.
interface kce_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [16:0] point_x;
  logic signed [15:0] point_alpha;
  modport source (output valid, req_type, point_x, point_alpha, input ready);
  modport sink (input valid, req_type, point_x, point_alpha, output ready);
endinterface

interface kce_rsp_if;
  logic valid;
  logic ready;
  logic [14:0] alpha_out;
  logic [2:0] status;
  modport source (output valid, alpha_out, status, input ready);
  modport sink (input valid, alpha_out, status, output ready);
endinterface

interface kce_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/kce_mac.sv
// Shared signed multiply-shift-add unit, registered result.
// Computes floor(a*b/2^sh) + c. Depends on nothing.
module kce_mac (
  input  logic               clk_i,
  input  logic signed [35:0] a_i,
  input  logic        [16:0] b_i,
  input  logic        [4:0]  sh_i,
  input  logic signed [35:0] c_i,
  output logic signed [35:0] r_o
);
  logic signed [53:0] prod;
  always_comb prod = a_i * $signed({1'b0, b_i});
  always_ff @(posedge clk_i) begin
    r_o <= 36'(prod >>> sh_i) + c_i;
  end
endmodule

// File: rtl/kce_div.sv
// Restoring divider, one quotient bit per cycle: q = floor(n*2^16/d), 16 bits.
// Depends on nothing.
module kce_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] num_i,
  input  logic [16:0] den_i,
  output logic        done_o,
  output logic [15:0] q_o
);
  logic [17:0] rem_q;
  logic [16:0] den_q;
  logic [15:0] q_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [17:0] sh;
  always_comb sh = {rem_q[16:0], 1'b0};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      // flag goes high together with the last quotient bit
      done_q <= busy_q && cnt_q == 5'd1;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) busy_q <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_q <= sh - {1'b0, den_q};
        q_q <= {q_q[14:0], 1'b1};
      end else begin
        rem_q <= sh;
        q_q <= {q_q[14:0], 1'b0};
      end
    end
  end
  assign done_o = done_q;
  assign q_o = q_q;
endmodule

// File: rtl/keyframe_curve_evaluator_top.sv
// Keyframe curve evaluator top: point table, sequencer, shared MAC and divider.
// Depends on kce_pkg, kce_if, kce_mac, kce_div.
//
// Usage: req channel takes an insert (req_type 0) or an evaluate (req_type 1)
// item; rsp channel returns one result (alpha_out, status) per item. The cfg
// channel writes curve_mode, start_alpha and end_alpha; the user must write
// them only while the block idles, as the block itself does not enforce it.
// One item at a time: req ready is high only in the idle state with no result
// waiting, so the next item can be taken from the cycle after the result
// transfers. Insert: an endpoint insert, a replace or a full table ends after
// the scan; a new point scans to the slot, shifts one entry a cycle to open
// it, is written, and then the result is loaded. Evaluate: a scan finds the
// segment, the neighbour points are fetched, the one-bit-a-cycle divider
// runs, then the shared multiply-add runs the linear or Catmull-Rom step (any
// other mode gives a constant) and the result is loaded.
// Positions at or past 1.0 return straight from the search step.
// Reset empties the table and sets linear mode, start and end alpha to 1.0.
// A stalled receiver holds the result in the output register; no new item is
// taken until it is transferred.
module keyframe_curve_evaluator_top #(
  parameter int unsigned MAX_POINTS = kce_pkg::MaxPointsDef
) (
  input logic clk_i,
  input logic rst_ni,
  kce_req_if.sink   req,
  kce_rsp_if.source rsp,
  kce_cfg_if.sink   cfg
);
  import kce_pkg::*;
  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 2);

  logic [XW-1:0] pos_mem [MAX_POINTS];
  logic signed [AW-1:0] alp_mem [MAX_POINTS];

  logic [1:0] mode_q;
  logic signed [AW-1:0] sa_q, ea_q;
  logic [CW-1:0] cnt_q, k_q, k_d;
  logic [CW-1:0] sub_k_q;
  state_e st_q, st_d;
  logic typ_q;
  logic [XW-1:0] x_q;
  logic signed [AW-1:0] a_q;
  logic [OW-1:0] out_a_q;
  logic [SW-1:0] out_s_q;
  logic ovld_q;
  logic [2:0] sub_q;
  logic signed [AW-1:0] p_q [4];
  logic [XW-1:0] x0_q, x1_q;
  logic [15:0] t_q;

  // full-curve position at index k (0 start, n+1 end)
  function automatic logic [XW-1:0] pos_at(input logic [CW-1:0] k,
      input logic [CW-1:0] n, input logic [XW-1:0] m);
    if (k == '0) return '0;
    if (k > n) return OneX;
    return m;
  endfunction

  logic [IW-1:0] scan_ix;
  logic [XW-1:0] scan_pos;
  logic signed [AW-1:0] scan_alp;
  always_comb begin
    scan_ix = IW'(k_q - CW'(1));
    scan_pos = pos_mem[scan_ix];
    scan_alp = alp_mem[scan_ix];
  end

  // fetch index for neighbour points: seg is i=k_q, points i-2..i+1
  logic [CW-1:0] f_k;
  logic [IW-1:0] f_ix;
  logic signed [AW-1:0] f_alp;
  always_comb begin
    unique case (sub_q[1:0])
      2'd0: f_k = (k_q >= CW'(2)) ? k_q - CW'(2) : '0;
      2'd1: f_k = k_q - CW'(1);
      2'd2: f_k = k_q;
      default: f_k = (k_q == cnt_q + CW'(1)) ? k_q : k_q + CW'(1);
    endcase
    f_ix = IW'(f_k - CW'(1));
    if (f_k == '0) f_alp = sa_q;
    else if (f_k > cnt_q) f_alp = ea_q;
    else f_alp = alp_mem[f_ix];
  end

  logic div_start, div_done;
  logic [15:0] div_q;
  logic [XW-1:0] dnum, dden;
  assign dnum = x_q - x0_q;
  assign dden = x1_q - x0_q;
  kce_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(dnum),
    .den_i(dden), .done_o(div_done), .q_o(div_q));

  // coefficients
  logic signed [33:0] c0, c1, c2, c3;
  always_comb begin
    c0 = 34'(2 * 34'(p_q[1]));
    c1 = 34'(p_q[2]) - 34'(p_q[0]);
    c2 = 34'(2 * 34'(p_q[0])) - 34'(5 * 34'(p_q[1])) + 34'(4 * 34'(p_q[2]))
       - 34'(p_q[3]);
    c3 = 34'(3 * 34'(p_q[1])) - 34'(3 * 34'(p_q[2])) + 34'(p_q[3]) - 34'(p_q[0]);
  end

  // Catmull-Rom: seed with c3 on the first pass, then chain the MAC result
  logic signed [35:0] m_a;
  logic [16:0] m_b;
  logic [4:0] m_sh;
  logic signed [35:0] m_c, m_r;
  always_comb begin
    m_a = (sub_q == 3'd0) ? 36'(c3) <<< 16 : m_r;
    m_b = {1'b0, t_q};
    m_sh = 5'd16;
    m_c = '0;
    if (mode_q == ModeLin) begin
      // floor(d*t/2^15) + 1, halved later, rounds d*t/2^16 to nearest
      m_a = 36'(p_q[2]) - 36'(p_q[1]);
      m_sh = 5'd15;
      m_c = 36'sd1;
    end else begin
      unique case (sub_q[1:0])
        2'd0: m_c = 36'(c2) <<< 16;
        2'd1: m_c = 36'(c1) <<< 16;
        default: m_c = 36'(c0) <<< 16;
      endcase
    end
  end
  kce_mac u_mac (.clk_i, .a_i(m_a), .b_i(m_b), .sh_i(m_sh), .c_i(m_c), .r_o(m_r));

  logic acc_req, acc_rsp;
  assign req.ready = (st_q == S_IDLE) && !ovld_q;
  assign acc_req = req.valid && req.ready;
  assign acc_rsp = rsp.valid && rsp.ready;
  assign cfg.ready = 1'b1;
  assign rsp.valid = ovld_q;
  assign rsp.alpha_out = out_a_q;
  assign rsp.status = out_s_q;

  logic scan_hit;
  always_comb begin
    scan_hit = (k_q > cnt_q) || !(scan_pos < x_q);
    if (typ_q) scan_hit = (k_q > cnt_q) || (x_q < scan_pos);
  end

  always_comb begin
    st_d = st_q;
    k_d = k_q;
    unique case (st_q)
      S_IDLE: if (acc_req) begin
        st_d = S_SEARCH; k_d = CW'(1);
      end
      S_SEARCH: begin
        if (!typ_q) begin
          if (x_q == '0 || x_q >= OneX) st_d = S_DONE;
          else if (scan_hit) begin
            if (k_q <= cnt_q && scan_pos == x_q) st_d = S_DONE;
            else if (cnt_q >= CW'(MAX_POINTS)) st_d = S_DONE;
            else begin st_d = S_SHIFT; k_d = cnt_q + CW'(1); end
          end else k_d = k_q + CW'(1);
        end else begin
          if (x_q >= OneX) st_d = S_DONE;
          else if (scan_hit || k_q == cnt_q + CW'(1)) st_d = S_FETCH;
          else k_d = k_q + CW'(1);
        end
      end
      S_SHIFT: if (k_q == sub_k_q) st_d = S_WRITE; else k_d = k_q - CW'(1);
      S_WRITE: st_d = S_DONE;
      S_FETCH: if (sub_q == 3'd4) st_d = S_DIV;
      S_DIV: if (div_done) st_d = S_POLY;
      S_POLY: begin
        if (mode_q == ModeLin && sub_q == 3'd1) st_d = S_DONE;
        else if (mode_q == ModeCr && sub_q == 3'd3) st_d = S_DONE;
        else if (mode_q != ModeLin && mode_q != ModeCr) st_d = S_DONE;
      end
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  assign div_start = (st_q == S_FETCH) && sub_q == 3'd4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      mode_q <= '0;
      sa_q <= 16'sd16384;
      ea_q <= 16'sd16384;
      ovld_q <= 1'b0;
      sub_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg.valid) begin
        unique case (cfg.index)
          RegMode: mode_q <= cfg.data[1:0];
          RegStart: sa_q <= cfg.data;
          RegEnd: ea_q <= cfg.data;
          default: ;
        endcase
      end
      if (acc_rsp) ovld_q <= 1'b0;
      if (st_q == S_DONE) ovld_q <= 1'b1;
      if (st_q == S_WRITE) cnt_q <= cnt_q + CW'(1);
      if (st_d != st_q) sub_q <= '0;
      else sub_q <= sub_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    if (acc_req) begin
      typ_q <= req.req_type; x_q <= req.point_x; a_q <= req.point_alpha;
    end
    unique case (st_q)
      S_SEARCH: begin
        sub_k_q <= k_q;
        if (!typ_q) begin
          out_a_q <= '0;
          if (x_q == '0 || x_q >= OneX) out_s_q <= StEndp;
          else if (scan_hit && k_q <= cnt_q && scan_pos == x_q) begin
            alp_mem[scan_ix] <= a_q; out_s_q <= StRepl;
          end else if (scan_hit && cnt_q >= CW'(MAX_POINTS)) out_s_q <= StFull;
          else out_s_q <= StIns;
        end else begin
          out_s_q <= StEval;
          out_a_q <= clamp_alpha(48'(ea_q));
          x1_q <= pos_at(k_q, cnt_q, scan_pos);
        end
      end
      S_SHIFT: if (k_q != sub_k_q) begin
        pos_mem[IW'(k_q - CW'(1))] <= pos_mem[IW'(k_q - CW'(2))];
        alp_mem[IW'(k_q - CW'(1))] <= alp_mem[IW'(k_q - CW'(2))];
      end
      S_WRITE: begin
        pos_mem[IW'(sub_k_q - CW'(1))] <= x_q;
        alp_mem[IW'(sub_k_q - CW'(1))] <= a_q;
      end
      S_FETCH: begin
        if (sub_q < 3'd4) p_q[sub_q[1:0]] <= f_alp;
        if (sub_q == 3'd1)
          x0_q <= pos_at(f_k, cnt_q, pos_mem[f_ix]);
      end
      S_DIV: if (div_done) t_q <= div_q;
      S_POLY: begin
        if (mode_q == ModeLin) begin
          if (sub_q == 3'd1) out_a_q <= clamp_alpha(48'(m_r >>> 1) + 48'(p_q[1]));
        end else if (mode_q == ModeCr) begin
          if (sub_q == 3'd3)
            out_a_q <= clamp_alpha((48'(m_r) + 48'sd65536) >>> 17);
        end else out_a_q <= OneAlpha;
      end
      default: ;
    endcase
  end
endmodule
